FILE: rtl/conv3_pkg.sv
package conv3_pkg;

   // Frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // Field widths
   localparam int PIX_W   = 16;
   localparam int COEF_W  = 16;
   localparam int ROW_W   = 3 * COEF_W;
   localparam int SUM_W   = 32;
   localparam int COORD_W = 10;
   localparam int DIM_W   = 11;
   localparam int CSR_IDX_W = 3;

   // Column / row counter widths follow the frame limits
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_CNT_W = $clog2(MAX_HEIGHT);

   // Width used for dimension compares, wide enough for the limits and the register
   localparam int DIMC_W = ((COL_W + 1) > DIM_W) ?
                           (((ROW_CNT_W + 1) > (COL_W + 1)) ? ROW_CNT_W + 1 : COL_W + 1) :
                           (((ROW_CNT_W + 1) > DIM_W) ? ROW_CNT_W + 1 : DIM_W);

   localparam int KTAPS = 9;

   typedef logic [PIX_W-1:0]  pix_type;
   typedef logic [ROW_W-1:0]  coef_row_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [DIMC_W-1:0] dimc_type;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_TOP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_MID = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BOT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 3'd4;

   // Reset values
   localparam coef_row_type COEFF_TOP_RST = '0;
   localparam coef_row_type COEFF_MID_RST = coef_row_type'(48'h0000_0001_0000);
   localparam coef_row_type COEFF_BOT_RST = '0;
   localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1024);
   localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1024);

   localparam dimc_type DIM_MIN  = DIMC_W'(3);
   localparam dimc_type WIDTH_MAXC  = DIMC_W'(MAX_WIDTH);
   localparam dimc_type HEIGHT_MAXC = DIMC_W'(MAX_HEIGHT);

   // Bring a programmed dimension into the supported range
   function automatic dimc_type clamp_dim(input logic [DIM_W-1:0] v, input dimc_type maxv);
      dimc_type ve;
      ve = DIMC_W'(v);
      if (ve < DIM_MIN) begin
         return DIM_MIN;
      end else if (ve > maxv) begin
         return maxv;
      end
      return ve;
   endfunction

endpackage

FILE: rtl/image_convolution_3x3.sv
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | req_pixel
// rsp     | out       | rsp_valid/stall   | rsp_sum_value, rsp_center_x, rsp_center_y,
//         |           |                   | rsp_frame_end
// csr     | in        | csr_valid/ready   | csr_index, csr_data
//
// One pixel is taken every cycle while req_stall is low. Results pass stage A (line
// store read), stage B (nine parallel products), then the adder tree into the result
// register. The line stores share one memory port pair, read at accept and written
// back in the cycle after. Reset sets the configuration and clears counters and
// window, not the line store. A stalled result holds back only the full stages.
module image_convolution_3x3 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [conv3_pkg::PIX_W-1:0]          req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [conv3_pkg::SUM_W-1:0]   rsp_sum_value,
   output logic [conv3_pkg::COORD_W-1:0]        rsp_center_x,
   output logic [conv3_pkg::COORD_W-1:0]        rsp_center_y,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [conv3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [conv3_pkg::ROW_W-1:0]          csr_data
);

   localparam int PW = conv3_pkg::PIX_W;
   localparam int CW = conv3_pkg::COL_W;
   localparam int RW = conv3_pkg::ROW_CNT_W;
   localparam int DW = conv3_pkg::DIMC_W;
   localparam int KW = conv3_pkg::COEF_W;
   localparam int SW = conv3_pkg::SUM_W;
   localparam int XW = conv3_pkg::COORD_W;

   // Configuration
   conv3_pkg::coef_row_type coeff_ff [3];
   logic [conv3_pkg::DIM_W-1:0] width_ff;
   logic [conv3_pkg::DIM_W-1:0] height_ff;

   // Counters
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;

   // Line store: {older row, newer row} per column
   logic [2*PW-1:0] line_mem [conv3_pkg::MAX_WIDTH];
   logic            wr_pend_ff;

   // Stage A: pixel, line store read, position flags
   logic            a_vld_ff, a_vld_in;
   logic [PW-1:0]   a_pix_ff;
   logic [2*PW-1:0] a_rd_ff;
   logic [CW-1:0]   a_x_ff;
   logic            a_emit_ff;
   logic            a_fend_ff;
   logic [XW-1:0]   a_cx_ff, a_cy_ff;

   // Window: two older columns, three rows each
   logic [PW-1:0]   win_ff [6];
   logic [PW-1:0]   col [3];

   // Stage B: products
   logic            b_vld_ff, b_vld_in;
   logic [SW-1:0]   b_prod_ff [conv3_pkg::KTAPS];
   logic [SW-1:0]   prod [conv3_pkg::KTAPS];
   logic [XW-1:0]   b_cx_ff, b_cy_ff;
   logic            b_fend_ff;

   // Result register
   logic            rsp_vld_ff, rsp_vld_in;
   logic [SW-1:0]   rsp_sum_ff;
   logic [XW-1:0]   rsp_cx_ff, rsp_cy_ff;
   logic            rsp_fend_ff;
   logic [SW-1:0]   sum_tree;

   logic accept, out_free, b_free, a_adv;
   conv3_pkg::dimc_type w_c, h_c, x_e, y_e;
   logic last_col, last_row, emit;

   // Handshake
   assign out_free  = ~rsp_vld_ff | ~rsp_stall;
   assign b_free    = ~b_vld_ff | out_free;
   assign a_adv     = a_vld_ff & b_free;
   assign req_stall = a_vld_ff & ~b_free;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // Position of the incoming pixel
   always_comb begin
      w_c      = conv3_pkg::clamp_dim(width_ff, conv3_pkg::WIDTH_MAXC);
      h_c      = conv3_pkg::clamp_dim(height_ff, conv3_pkg::HEIGHT_MAXC);
      x_e      = DW'(col_cnt_ff);
      y_e      = DW'(row_cnt_ff);
      last_col = (x_e >= w_c - DW'(1));
      last_row = (y_e >= h_c - DW'(1));
      emit     = (x_e >= DW'(2)) && (y_e >= DW'(2)) && (x_e < w_c) && (y_e < h_c);
      if (last_col) begin
         col_cnt_in = '0;
         row_cnt_in = last_row ? '0 : row_cnt_ff + RW'(1);
      end else begin
         col_cnt_in = col_cnt_ff + CW'(1);
         row_cnt_in = row_cnt_ff;
      end
   end

   // Current column and the nine products
   always_comb begin
      col[0] = a_rd_ff[2*PW-1:PW];
      col[1] = a_rd_ff[PW-1:0];
      col[2] = a_pix_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            logic signed [KW:0]     pix_s;
            logic signed [KW-1:0]   k;
            logic signed [KW+PW:0]  p;
            k     = $signed(coeff_ff[r][c*KW +: KW]);
            pix_s = $signed({1'b0, (c < 2) ? win_ff[c*3+r] : col[r]});
            p     = k * pix_s;
            prod[r*3+c] = SW'(p);
         end
      end
   end

   // Wrapping sum of the products
   always_comb begin
      sum_tree = '0;
      for (int i = 0; i < conv3_pkg::KTAPS; i++) begin
         sum_tree = sum_tree + b_prod_ff[i];
      end
   end

   assign a_vld_in   = accept | (a_vld_ff & ~a_adv);
   assign b_vld_in   = (a_adv & a_emit_ff) | (b_vld_ff & ~out_free);
   assign rsp_vld_in = (b_vld_ff & out_free) | (rsp_vld_ff & rsp_stall);

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff[0] <= conv3_pkg::COEFF_TOP_RST;
         coeff_ff[1] <= conv3_pkg::COEFF_MID_RST;
         coeff_ff[2] <= conv3_pkg::COEFF_BOT_RST;
         width_ff    <= conv3_pkg::WIDTH_RST;
         height_ff   <= conv3_pkg::HEIGHT_RST;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         wr_pend_ff  <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         wr_pend_ff <= accept;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
         // Shift the window as each pixel leaves stage A
         if (a_adv) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[r]   <= win_ff[3+r];
               win_ff[3+r] <= col[r];
            end
         end
         // Write configuration registers
         if (csr_valid) begin
            case (csr_index)
               conv3_pkg::CSR_COEFF_TOP: coeff_ff[0] <= csr_data;
               conv3_pkg::CSR_COEFF_MID: coeff_ff[1] <= csr_data;
               conv3_pkg::CSR_COEFF_BOT: coeff_ff[2] <= csr_data;
               conv3_pkg::CSR_WIDTH:     width_ff    <= csr_data[conv3_pkg::DIM_W-1:0];
               conv3_pkg::CSR_HEIGHT:    height_ff   <= csr_data[conv3_pkg::DIM_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Line store: read at accept, write back the shifted pair in the cycle after
   always_ff @(posedge clock) begin
      if (accept) begin
         a_rd_ff <= line_mem[col_cnt_ff];
      end
      if (wr_pend_ff) begin
         line_mem[a_x_ff] <= {a_rd_ff[PW-1:0], a_pix_ff};
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff  <= req_pixel;
         a_x_ff    <= col_cnt_ff;
         a_emit_ff <= emit;
         a_fend_ff <= last_col && last_row && (x_e == w_c - DW'(1)) &&
                      (y_e == h_c - DW'(1));
         a_cx_ff   <= XW'(col_cnt_ff - CW'(1));
         a_cy_ff   <= XW'(row_cnt_ff - RW'(1));
      end
      if (a_adv) begin
         for (int i = 0; i < conv3_pkg::KTAPS; i++) begin
            b_prod_ff[i] <= prod[i];
         end
         b_cx_ff   <= a_cx_ff;
         b_cy_ff   <= a_cy_ff;
         b_fend_ff <= a_fend_ff;
      end
      if (b_vld_ff & out_free) begin
         rsp_sum_ff  <= sum_tree;
         rsp_cx_ff   <= b_cx_ff;
         rsp_cy_ff   <= b_cy_ff;
         rsp_fend_ff <= b_fend_ff;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_sum_value = $signed(rsp_sum_ff);
   assign rsp_center_x  = rsp_cx_ff;
   assign rsp_center_y  = rsp_cy_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule

FILE: rtl/conv3_checker.sv
module conv3_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [conv3_pkg::SUM_W-1:0]   rsp_sum_value,
   input logic [conv3_pkg::COORD_W-1:0]        rsp_center_x,
   input logic [conv3_pkg::COORD_W-1:0]        rsp_center_y,
   input logic                                 rsp_frame_end,
   input logic                                 csr_ready
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_value) &&
      $stable(rsp_center_x) && $stable(rsp_center_y) && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   // Drop all results at reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Results never sit on the top row or the left column
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_x != '0) && (rsp_center_y != '0))
      else $error("result on a border pixel");

   // Stall the input only behind a held result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the result side free");

   // Configuration writes are never back-pressured
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind image_convolution_3x3 conv3_checker u_conv3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_sum_value (rsp_sum_value),
   .rsp_center_x  (rsp_center_x),
   .rsp_center_y  (rsp_center_y),
   .rsp_frame_end (rsp_frame_end),
   .csr_ready     (csr_ready)
);
